>>> src/assert_macros.svh
// Assertion shorthands used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the clock after the antecedent.
`define ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked in the same clock as the antecedent.
`define ASSERT_SAME(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> src/gfed_pkg.sv
package gfed_pkg;

    localparam int LAT_W  = 31;
    localparam int LON_W  = 32;
    localparam int MAG_W  = 31;   // axis magnitude after wrap, 1e-7 degree
    localparam int DIST_W = 25;   // meters
    localparam int SUM_W  = 2 * DIST_W + 1;
    localparam int ROOT_STAGES = (SUM_W + 1) / 2;
    localparam int MET_LAT = 3;   // register stages in gfed_meters
    localparam int IN_W   = 2 * LAT_W + 2 * LON_W;

    typedef logic [MAG_W-1:0]  mag_t;
    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [7:0]        cos_t;

    // meters = floor(mag * DEG_TO_M_NUM / DEG_TO_M_DEN)
    localparam logic [16:0] DEG_TO_M_NUM   = 17'd111198;
    localparam logic [24:0] DEG_TO_M_DEN   = 25'd10000000;
    // floor(2^32 * NUM / DEN); rounding down keeps the estimate from overshooting
    localparam logic [25:0] DEG_TO_M_RECIP = 26'd47759177;
    localparam int          RECIP_SHIFT    = 32;

    localparam logic [31:0] HALF_TURN = 32'd1800000000;
    localparam logic [31:0] FULL_TURN = 32'd3600000000;

    localparam int COS_LAST = 54;
    localparam logic [7:0] COS_LUT [0:COS_LAST] = '{
        8'd0,   8'd0,   8'd0,   8'd255, 8'd254, 8'd253, 8'd252, 8'd251, 8'd249, 8'd247,
        8'd245, 8'd243, 8'd240, 8'd238, 8'd235, 8'd232, 8'd228, 8'd225, 8'd221, 8'd217,
        8'd213, 8'd209, 8'd205, 8'd200, 8'd195, 8'd190, 8'd185, 8'd180, 8'd175, 8'd169,
        8'd163, 8'd158, 8'd152, 8'd145, 8'd139, 8'd133, 8'd126, 8'd120, 8'd113, 8'd106,
        8'd100, 8'd93,  8'd86,  8'd79,  8'd71,  8'd64,  8'd57,  8'd49,  8'd42,  8'd35,
        8'd27,  8'd20,  8'd12,  8'd5,   8'd1
    };

    // Cosine entry for a latitude band; bands past the table use the last entry.
    function automatic cos_t cos_lookup(input logic [6:0] band);
        logic [5:0] idx;
        idx = (band > 7'(COS_LAST)) ? 6'(COS_LAST) : band[5:0];
        return COS_LUT[idx];
    endfunction

endpackage

>>> src/gfed_meters.sv
module gfed_meters import gfed_pkg::*; (
    input  logic  aclk,
    input  logic  en,
    input  mag_t  mag,
    output dist_t meters
);

    logic [MAG_W+25:0] recip_prod;
    logic [MAG_W+16:0] num_prod;
    logic [DIST_W+23:0] back_prod;
    dist_t             rem_lo;

    dist_t qe_a_reg, num_lo_a_reg;
    dist_t qe_b_reg, num_lo_b_reg, back_lo_b_reg;
    dist_t meters_reg;

    // estimate is the true quotient or one below it
    assign recip_prod = (MAG_W+26)'(mag) * (MAG_W+26)'(DEG_TO_M_RECIP);
    assign num_prod   = (MAG_W+17)'(mag) * (MAG_W+17)'(DEG_TO_M_NUM);
    assign back_prod  = (DIST_W+24)'(qe_a_reg) * (DIST_W+24)'(DEG_TO_M_DEN);
    // remainder stays below twice the divisor, so the low bits suffice
    assign rem_lo     = num_lo_b_reg - back_lo_b_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            qe_a_reg      <= recip_prod[RECIP_SHIFT +: DIST_W];
            num_lo_a_reg  <= num_prod[DIST_W-1:0];
            qe_b_reg      <= qe_a_reg;
            num_lo_b_reg  <= num_lo_a_reg;
            back_lo_b_reg <= back_prod[DIST_W-1:0];
            meters_reg    <= qe_b_reg + DIST_W'(rem_lo >= DEG_TO_M_DEN);
        end
    end

    assign meters = meters_reg;

endmodule

>>> src/gfed_isqrt.sv
module gfed_isqrt import gfed_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  sum_t  radicand,
    output logic  out_valid,
    output dist_t root
);

    localparam int RT_W = SUM_W + 1;

    logic            vld_reg  [ROOT_STAGES];
    sum_t            rem_reg  [ROOT_STAGES];
    logic [RT_W-1:0] root_reg [ROOT_STAGES];

    // one result bit per stage, highest first
    for (genvar i = 0; i < ROOT_STAGES; i++) begin : g_stage
        localparam logic [RT_W-1:0] BITC = RT_W'(1) << (2 * (ROOT_STAGES - 1 - i));

        logic            vld_in;
        sum_t            rem_in;
        logic [RT_W-1:0] root_in;
        logic [RT_W-1:0] trial;
        logic            take;

        if (i == 0) begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = radicand;
            assign root_in = '0;
        end else begin : g_next
            assign vld_in  = vld_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
        end

        assign trial = root_in + BITC;
        assign take  = {1'b0, rem_in} >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= take ? (rem_in - trial[SUM_W-1:0]) : rem_in;
                root_reg[i] <= take ? ((root_in >> 1) + BITC) : (root_in >> 1);
            end
        end
    end

    assign out_valid = vld_reg[ROOT_STAGES-1];
    assign root      = root_reg[ROOT_STAGES-1][DIST_W-1:0];

endmodule

>>> src/gps_flat_earth_distance_unit.sv
// Flat-earth distance between two GPS points, in whole meters.
// Input: one word per point pair on s_tvalid/s_tready/s_tdata. Coordinates
// are two's complement in units of 1e-7 degree. Output: one word per pair on
// m_tvalid/m_tready/m_tdata carrying the floor square root of the summed
// squared axis distances. Longitude takes the short way around and is
// scaled by a cosine entry picked from the first point's latitude band.
// Throughput: one word per cycle, sustained, while m_tready stays high.
// Pipeline: 34 register stages: two of difference and wrap, three in the
// meters divider (reciprocal multiply, back multiply, remainder fix), cosine,
// squares, sum, and 26 stages of the square root, one result bit each.
// Stall: the whole pipeline holds while an output word waits. A one-word
// skid register at the input still takes a word during a stall; s_tready
// drops only once that register is full and comes back the cycle after
// the pipeline advances again.
// Reset: aresetn (synchronous, active low) empties the pipeline and the
// skid register and holds s_tready low; no result is lost or repeated
// afterward.
module gps_flat_earth_distance_unit import gfed_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // lat_first[30:0], lon_first[62:31], lat_second[93:63],
    // lon_second[125:94], zero pad [127:126]
    input  logic [127:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // distance_m[24:0], zero pad [31:25]
    output logic [31:0]   m_tdata
);

    logic adv;      // whole pipeline steps forward
    logic s_acc;

    // input skid register
    logic              skid_valid_reg, skid_valid_next;
    logic [IN_W-1:0]   skid_data_reg;

    logic              p0_valid;
    logic [IN_W-1:0]   p0_data;
    logic [LAT_W-1:0]  lat_a, lat_b;
    logic [LON_W-1:0]  lon_a, lon_b;
    logic [31:0]       lat_a_abs;

    // stage 1: differences and cosine pick
    logic              v1_reg;
    logic [31:0]       lat_d_reg;
    logic [32:0]       lon_d_reg;
    cos_t              cos1_reg;

    // stage 2: magnitudes, longitude wrap
    logic [31:0]       lat_d_abs;
    logic [32:0]       lon_d_abs;
    logic [31:0]       lon_wrap;
    logic              v2_reg;
    mag_t              lat_mag_reg, lon_mag_reg;
    cos_t              cos2_reg;

    // alongside the meters divider
    logic              vm_reg  [MET_LAT];
    cos_t              cosm_reg [MET_LAT];
    dist_t             lat_m, lon_m;

    // stage 3: cosine scale
    logic [DIST_W+7:0] lon_small_prod;
    logic [DIST_W-1:0] lon_big_prod;
    dist_t             lon_scaled;
    logic              v3_reg;
    dist_t             lat_m3_reg, lon_s3_reg;

    // stage 4 and 5: squares and sum
    logic              v4_reg, v5_reg;
    logic [2*DIST_W-1:0] lat_sq_reg, lon_sq_reg;
    sum_t              sum_reg;

    dist_t             root;

    assign adv      = !m_tvalid || m_tready;
    // hold off the sender while in reset
    assign s_tready = aresetn && !skid_valid_reg;
    assign s_acc    = s_tvalid && s_tready;

    // drain skid first; otherwise pass the port straight in
    assign p0_valid = skid_valid_reg || s_acc;
    assign p0_data  = skid_valid_reg ? skid_data_reg : s_tdata[IN_W-1:0];

    assign lat_a = p0_data[LAT_W-1:0];
    assign lon_a = p0_data[LAT_W +: LON_W];
    assign lat_b = p0_data[LAT_W+LON_W +: LAT_W];
    assign lon_b = p0_data[2*LAT_W+LON_W +: LON_W];

    assign skid_valid_next = adv ? 1'b0 : (skid_valid_reg || s_acc);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && !adv) begin
            skid_data_reg <= s_tdata[IN_W-1:0];
        end
    end

    // latitude band of the first point: |lat| >> 24
    assign lat_a_abs = lat_a[LAT_W-1] ? (32'd0 - {lat_a[LAT_W-1], lat_a})
                                      : {1'b0, lat_a};

    // magnitudes; longitude goes the short way around the globe
    assign lat_d_abs = lat_d_reg[31] ? (32'd0 - lat_d_reg) : lat_d_reg;
    assign lon_d_abs = lon_d_reg[32] ? (33'd0 - lon_d_reg) : lon_d_reg;

    always_comb begin
        if (lon_d_abs[31:0] <= HALF_TURN) begin
            lon_wrap = lon_d_abs[31:0];
        end else if (lon_d_abs[31:0] >= FULL_TURN) begin
            lon_wrap = lon_d_abs[31:0] - FULL_TURN;
        end else begin
            lon_wrap = FULL_TURN - lon_d_abs[31:0];
        end
    end

    // large distances drop low bits before the multiply
    assign lon_small_prod = (DIST_W+8)'(lon_m) * (DIST_W+8)'(cosm_reg[MET_LAT-1]);
    assign lon_big_prod   = DIST_W'(lon_m[DIST_W-1:8]) * DIST_W'(cosm_reg[MET_LAT-1]);

    always_comb begin
        if (cosm_reg[MET_LAT-1] == 8'd0) begin
            lon_scaled = lon_m;
        end else if (lon_m[DIST_W-1:23] != '0) begin
            lon_scaled = lon_big_prod;
        end else begin
            lon_scaled = lon_small_prod[DIST_W+7:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            for (int i = 0; i < MET_LAT; i++) begin
                vm_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            v1_reg    <= p0_valid;
            v2_reg    <= v1_reg;
            vm_reg[0] <= v2_reg;
            for (int i = 1; i < MET_LAT; i++) begin
                vm_reg[i] <= vm_reg[i-1];
            end
            v3_reg <= vm_reg[MET_LAT-1];
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lat_d_reg <= {lat_a[LAT_W-1], lat_a} - {lat_b[LAT_W-1], lat_b};
            lon_d_reg <= {lon_a[LON_W-1], lon_a} - {lon_b[LON_W-1], lon_b};
            cos1_reg  <= cos_lookup(lat_a_abs[30:24]);

            lat_mag_reg <= lat_d_abs[MAG_W-1:0];
            lon_mag_reg <= lon_wrap[MAG_W-1:0];
            cos2_reg    <= cos1_reg;

            cosm_reg[0] <= cos2_reg;
            for (int i = 1; i < MET_LAT; i++) begin
                cosm_reg[i] <= cosm_reg[i-1];
            end

            lat_m3_reg <= lat_m;
            lon_s3_reg <= lon_scaled;

            lat_sq_reg <= (2*DIST_W)'(lat_m3_reg) * (2*DIST_W)'(lat_m3_reg);
            lon_sq_reg <= (2*DIST_W)'(lon_s3_reg) * (2*DIST_W)'(lon_s3_reg);

            sum_reg <= SUM_W'(lat_sq_reg) + SUM_W'(lon_sq_reg);
        end
    end

    gfed_meters u_lat_meters (
        .aclk   (aclk),
        .en     (adv),
        .mag    (lat_mag_reg),
        .meters (lat_m)
    );

    gfed_meters u_lon_meters (
        .aclk   (aclk),
        .en     (adv),
        .mag    (lon_mag_reg),
        .meters (lon_m)
    );

    gfed_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v5_reg),
        .radicand  (sum_reg),
        .out_valid (m_tvalid),
        .root      (root)
    );

    assign m_tdata = {(32-DIST_W)'(0), root};

endmodule

>>> src/gfed_checker.sv
`include "assert_macros.svh"

module gfed_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [31:0]  m_tdata
);

    // reset empties the output register
    `ASSERT_NEXT(a_rst_out_empty, aclk, 1'b0, !aresetn, !m_tvalid, "output valid after reset")

    // a waiting word holds until taken
    `ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")

    // pad bits above the distance stay zero
    `ASSERT_SAME(a_pad_zero, aclk, !aresetn, m_tvalid, m_tdata[31:25] == 7'd0, "nonzero pad bits in output word")

    // a full skid register drains as soon as the sink takes a word
    `ASSERT_NEXT(a_ready_back, aclk, !aresetn, !s_tready && m_tready, s_tready, "input ready stuck low")

endmodule

bind gps_flat_earth_distance_unit gfed_checker u_gfed_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/sv/gps_flat_earth_distance_unit_tb.sv
module gps_flat_earth_distance_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Meters per 1e-7 degree, as a ratio, and the wrap points of longitude.
    localparam longint unsigned METERS_NUM = 64'd111198;
    localparam longint unsigned METERS_DEN = 64'd10000000;
    localparam longint          HALF_TURN_U = 64'sd1800000000;
    localparam longint          FULL_TURN_U = 64'sd3600000000;
    // Bits 23..30 of the unscaled longitude meters pick the shift-first path.
    localparam longint unsigned SHIFT_FIRST_MASK = 64'h7f80_0000;
    localparam int unsigned     LAST_BAND = 54;

    // Raw field extremes, beyond the geographic range.
    localparam int LAT_MIN_RAW = -1073741824;
    localparam int LAT_MAX_RAW = 1073741823;
    localparam int LON_MIN_RAW = 32'h8000_0000;
    localparam int LON_MAX_RAW = 32'h7fff_ffff;

    // Drain margin after the last expected word: pipeline latency plus slack.
    localparam int DRAIN_CYCLES = 48;

    typedef struct {
        logic signed [30:0] lat_first;
        logic signed [31:0] lon_first;
        logic signed [30:0] lat_second;
        logic signed [31:0] lon_second;
    } point_pair_t;

    logic          aclk     = 1'b0;
    logic          aresetn  = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [127:0]  s_tdata  = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [31:0]   m_tdata;

    gfed_pkg::dist_t distance_expected_q[$];
    gfed_pkg::dist_t distance_want;
    int            mismatch_count = 0;
    int            pairs_sent     = 0;
    int            distances_seen = 0;
    bit            send_gaps_on   = 1'b0;
    bit            recv_stalls_on = 1'b0;

    gps_flat_earth_distance_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    // Floor square root, one result bit at a time from the top.
    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    // Ground distance in meters for one point pair.
    function automatic gfed_pkg::dist_t predict_distance(input point_pair_t p);
        longint          lat_a;
        longint          dlat;
        longint          dlon;
        longint unsigned lat_m;
        longint unsigned lon_m;
        longint unsigned band;
        longint unsigned cos_w;
        lat_a = longint'(p.lat_first);
        dlat  = lat_a - longint'(p.lat_second);
        if (dlat < 0)
            dlat = -dlat;
        lat_m = longint'(dlat) * METERS_NUM / METERS_DEN;

        // Take the short way around; past the field range the result may go
        // negative, so fold it back.
        dlon = longint'(p.lon_first) - longint'(p.lon_second);
        if (dlon < 0)
            dlon = -dlon;
        if (dlon > HALF_TURN_U)
            dlon = FULL_TURN_U - dlon;
        if (dlon < 0)
            dlon = -dlon;
        lon_m = longint'(dlon) * METERS_NUM / METERS_DEN;

        // Cosine band from the first latitude, saturated at the last entry.
        band = longint'(lat_a < 0 ? -lat_a : lat_a) >> 24;
        if (band > LAST_BAND)
            band = 64'(LAST_BAND);
        cos_w = 64'(gfed_pkg::COS_LUT[band]);
        if (cos_w != 0) begin
            if ((lon_m & SHIFT_FIRST_MASK) != 0)
                lon_m = (lon_m >> 8) * cos_w;
            else
                lon_m = (lon_m * cos_w) >> 8;
        end
        return gfed_pkg::dist_t'(floor_root(lat_m * lat_m + lon_m * lon_m));
    endfunction

    function automatic point_pair_t make_pair(input int lat_a, input int lon_a,
                                              input int lat_b, input int lon_b);
        point_pair_t p;
        p.lat_first  = lat_a[30:0];
        p.lon_first  = lon_a;
        p.lat_second = lat_b[30:0];
        p.lon_second = lon_b;
        return p;
    endfunction

    function automatic int rand_lat();
        return int'($urandom_range(0, 1800000000)) - 900000000;
    endfunction

    function automatic int rand_lon();
        return int'(longint'($urandom_range(0, 32'd3600000000)) - 64'sd1800000000);
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Drive one point pair and hold it until the block takes the word.
    task automatic send_pair(input point_pair_t p);
        @(negedge aclk);
        if (send_gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, p.lon_second, p.lat_second, p.lon_first, p.lat_first};
        do @(posedge aclk); while (!s_tready);
        distance_expected_q.push_back(predict_distance(p));
        pairs_sent++;
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (distance_expected_q.size() != 0)
            @(posedge aclk);
    endtask

    // Receiver: stall in random bursts while enabled, otherwise stay ready.
    always begin
        @(negedge aclk);
        if (recv_stalls_on && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        m_tready <= 1'b1;
    end

    // Compare every accepted distance word with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            distances_seen++;
            if (distance_expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected distance word %0d", m_tdata[24:0]));
            end else begin
                distance_want = distance_expected_q.pop_front();
                if (m_tdata[24:0] !== distance_want)
                    report_mismatch($sformatf("distance_m got %0d want %0d",
                                              m_tdata[24:0], distance_want));
            end
        end
    end

    // Extremes of every field, the wrap through 360 degrees, and the cosine
    // bands: unscaled, first scaled, saturated, and both scaling orders.
    task automatic test_directed();
        send_pair(make_pair(0, 0, 0, 0));
        send_pair(make_pair(900000000, 0, -900000000, 0));
        send_pair(make_pair(-900000000, 1800000000, 900000000, -1800000000));
        send_pair(make_pair(0, 1800000000, 0, -1800000000));
        send_pair(make_pair(0, 900000000, 0, -900000000));
        send_pair(make_pair(0, 900000001, 0, -900000000));
        send_pair(make_pair(0, -1800000000, 0, 0));
        send_pair(make_pair(LAT_MIN_RAW, LON_MIN_RAW, LAT_MAX_RAW, LON_MAX_RAW));
        send_pair(make_pair(LAT_MAX_RAW, LON_MAX_RAW, LAT_MIN_RAW, LON_MIN_RAW));
        send_pair(make_pair(LAT_MIN_RAW, 0, LAT_MAX_RAW, 0));
        send_pair(make_pair(0, LON_MIN_RAW, 0, 0));
        send_pair(make_pair(0, LON_MAX_RAW, 0, 0));
        send_pair(make_pair(50331647, 123456789, 0, 0));
        send_pair(make_pair(50331648, 123456789, 0, 0));
        send_pair(make_pair(905969664, 100000000, 0, 0));
        send_pair(make_pair(LAT_MIN_RAW, 100000000, 0, 0));
        send_pair(make_pair(-600000000, 1000000000, 0, 0));
        send_pair(make_pair(100000000, 754000000, 100000000, 0));
        send_pair(make_pair(100000000, 755000000, 100000000, 0));
        send_pair(make_pair(1, -1, 0, 0));
        send_pair(make_pair(-1, 0, 0, 1));
        send_pair(make_pair(-899999999, -1799999999, 899999999, 1799999999));
    endtask

    function automatic point_pair_t random_pair();
        point_pair_t p;
        int          kind;
        int          lat_a;
        int          lon_a;
        kind  = $urandom_range(0, 99);
        lat_a = rand_lat();
        lon_a = rand_lon();
        p = make_pair(lat_a, lon_a, rand_lat(), rand_lon());
        if (kind >= 60 && kind < 75) begin
            // Points on either side of the date line.
            p.lon_first  = 1800000000 - int'($urandom_range(0, 20000000));
            p.lon_second = -1800000000 + int'($urandom_range(0, 20000000));
            if ($urandom_range(0, 1))
                p.lon_first = -p.lon_first;
            if ($urandom_range(0, 1))
                p.lon_second = -p.lon_second;
        end else if (kind >= 75 && kind < 85) begin
            // Nearby points.
            p.lat_second = 31'(lat_a + int'($urandom_range(0, 2000000)) - 1000000);
            p.lon_second = lon_a + int'($urandom_range(0, 2000000)) - 1000000;
        end else if (kind >= 85 && kind < 95) begin
            // First latitude at a band edge, either sign.
            lat_a = (int'($urandom_range(0, 63)) << 24) + int'($urandom_range(0, 4)) - 2;
            if ($urandom_range(0, 1))
                lat_a = -lat_a;
            p.lat_first = lat_a[30:0];
        end else if (kind >= 95) begin
            // Raw bits across the whole field width.
            p.lat_first  = 31'($urandom());
            p.lon_first  = $urandom();
            p.lat_second = 31'($urandom());
            p.lon_second = $urandom();
        end
        return p;
    endfunction

    // Random pairs in chunks; each chunk picks its own gap and stall mix.
    task automatic test_random(input int chunks, input int per_chunk);
        for (int c = 0; c < chunks; c++) begin
            send_gaps_on   = ($urandom_range(0, 2) != 0);
            recv_stalls_on = ($urandom_range(0, 2) != 0);
            for (int i = 0; i < per_chunk; i++)
                send_pair(random_pair());
        end
    endtask

    // Hold off the sender until the pipeline has emptied, then resume.
    task automatic test_drain_pause();
        send_gaps_on   = 1'b0;
        recv_stalls_on = 1'b1;
        for (int i = 0; i < 20; i++)
            send_pair(random_pair());
        drop_valid();
        wait_drained();
        for (int i = 0; i < 20; i++)
            send_pair(random_pair());
    endtask

    // Back-to-back words with both sides always ready.
    task automatic test_full_rate();
        send_gaps_on   = 1'b0;
        recv_stalls_on = 1'b0;
        for (int i = 0; i < 150; i++)
            send_pair(random_pair());
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_drain_pause();
        test_random(21, 50);
        test_full_rate();

        drop_valid();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d point pairs: field extremes, date-line wrap, cosine bands,",
                 pairs_sent);
        $display("random pairs under sender gaps and receiver stalls; %0d distances checked",
                 distances_seen);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Bound the run well past the slowest correct run.
    initial begin
        #5ms;
        $display("timeout with %0d distances pending", distance_expected_q.size());
        $display("FAIL");
        $finish;
    end

endmodule
